// ===== hw/rtl/sorted_priority_queue_macros.svh =====
// Assertion macros shared by the sorted priority queue checkers.
// Each macro expects clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: same-cycle check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DataW  = 32;
  localparam int CountW = 5;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares with the incoming word.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_ctl_t               ctl,
  input  logic                             occ,
  input  logic signed [spq_pkg::DataW-1:0] item_data,
  input  logic signed [spq_pkg::DataW-1:0] item_pri,
  input  logic                             left_after,
  input  logic signed [spq_pkg::DataW-1:0] left_data,
  input  logic signed [spq_pkg::DataW-1:0] left_pri,
  input  logic signed [spq_pkg::DataW-1:0] right_data,
  input  logic signed [spq_pkg::DataW-1:0] right_pri,
  output logic                             after,
  output logic signed [spq_pkg::DataW-1:0] data,
  output logic signed [spq_pkg::DataW-1:0] pri
);

  logic signed [spq_pkg::DataW-1:0] data_r, data_nxt;
  logic signed [spq_pkg::DataW-1:0] pri_r, pri_nxt;

  // new word belongs at or before this slot (strictly greater keeps ties stable)
  assign after = !occ || (pri_r > item_pri);

  always_comb begin
    data_nxt = data_r;
    pri_nxt  = pri_r;
    if (ctl.enq) begin
      if (left_after) begin
        data_nxt = left_data;
        pri_nxt  = left_pri;
      end else if (after) begin
        data_nxt = item_data;
        pri_nxt  = item_pri;
      end
    end else if (ctl.deq) begin
      data_nxt = right_data;
      pri_nxt  = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pri_r  <= pri_nxt;
  end

  assign data = data_r;
  assign pri  = pri_r;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue: top level, a chain of spq_cell slots plus count and result register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel in_*: op (0 enqueue, 1 dequeue head), item_data, item_priority.
//   A word is taken when in_valid is high and in_stall is low.
//   Result channel out_*: one word per input word with status, head_data,
//   head_priority, now_empty and entry_count, taken when out_valid is high
//   and out_stall is low.
//   The result is registered at the edge that takes the input word. Throughput
//   is one word per cycle while in_stall is low; every slot compares against
//   the incoming priority in parallel and shifts by one position in the same
//   cycle, so the chain itself never holds a word back.
//   While a result waits and out_stall is high, in_stall is high and the
//   chain holds; the pending result and its payload stay unchanged.
//   Reset empties the queue (count to zero) and drops any pending result.
//   Enqueue on a full queue and dequeue on an empty one leave the queue
//   unchanged and report status 2 or 1 with zero head fields.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic signed [spq_pkg::DataW-1:0] in_item_data,
  input  logic signed [spq_pkg::DataW-1:0] in_item_priority,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic signed [spq_pkg::DataW-1:0] out_head_data,
  output logic signed [spq_pkg::DataW-1:0] out_head_priority,
  output logic                             out_now_empty,
  output logic [spq_pkg::CountW-1:0]       out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic signed [spq_pkg::DataW-1:0] head_data_r, head_data_nxt;
  logic signed [spq_pkg::DataW-1:0] head_pri_r, head_pri_nxt;
  logic          empty_r;
  logic [spq_pkg::CountW-1:0] entry_count_r;

  logic               accept, full, empty;
  spq_pkg::cell_ctl_t ctl;

  logic                             after_w [CAPACITY];
  logic signed [spq_pkg::DataW-1:0] data_w  [CAPACITY];
  logic signed [spq_pkg::DataW-1:0] pri_w   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign ctl.enq  = accept && (in_op == spq_pkg::OP_ENQ) && !full;
  assign ctl.deq  = accept && (in_op == spq_pkg::OP_DEQ) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                             l_after;
    logic signed [spq_pkg::DataW-1:0] l_data, l_pri, r_data, r_pri;

    if (i == 0) begin : g_first
      assign l_after = 1'b0;
      assign l_data  = in_item_data;
      assign l_pri   = in_item_priority;
    end else begin : g_mid
      assign l_after = after_w[i-1];
      assign l_data  = data_w[i-1];
      assign l_pri   = pri_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = data_w[i];
      assign r_pri  = pri_w[i];
    end else begin : g_inner
      assign r_data = data_w[i+1];
      assign r_pri  = pri_w[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (CW'(i) < count_r),
      .item_data  (in_item_data),
      .item_pri   (in_item_priority),
      .left_after (l_after),
      .left_data  (l_data),
      .left_pri   (l_pri),
      .right_data (r_data),
      .right_pri  (r_pri),
      .after      (after_w[i]),
      .data       (data_w[i]),
      .pri        (pri_w[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = spq_pkg::ST_DONE;
    head_data_nxt = '0;
    head_pri_nxt  = '0;
    if (in_op == spq_pkg::OP_ENQ) begin
      if (full) status_nxt = spq_pkg::ST_FULL;
      else      count_nxt  = count_r + CW'(1);
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        count_nxt     = count_r - CW'(1);
        head_data_nxt = data_w[0];
        head_pri_nxt  = pri_w[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      head_data_r   <= head_data_nxt;
      head_pri_r    <= head_pri_nxt;
      empty_r       <= (count_nxt == '0);
      entry_count_r <= spq_pkg::CountW'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_data     = head_data_r;
  assign out_head_priority = head_pri_r;
  assign out_now_empty     = empty_r;
  assign out_entry_count   = entry_count_r;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg, sorted_priority_queue_macros.svh and sorted_priority_queue.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_status,
  input logic signed [spq_pkg::DataW-1:0] out_head_data,
  input logic signed [spq_pkg::DataW-1:0] out_head_priority,
  input logic                             out_now_empty,
  input logic [spq_pkg::CountW-1:0]       out_entry_count
);

  logic refused, head_zero, empty_status, empty_report, count_nonzero;

  assign refused       = out_valid && (out_status != spq_pkg::ST_DONE);
  assign head_zero     = (out_head_data == '0) && (out_head_priority == '0);
  assign empty_status  = out_valid && (out_status == spq_pkg::ST_EMPTY);
  assign empty_report  = out_now_empty && (out_entry_count == '0);
  assign count_nonzero = out_valid && (out_entry_count != '0);

  // input side only backs up behind a waiting result
  `SPQ_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid && out_stall)
  `SPQ_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid)
  `SPQ_ASSERT_NOW(a_refused_zero_head, refused, head_zero)
  `SPQ_ASSERT_NOW(a_empty_flags, empty_status, empty_report)
  `SPQ_ASSERT_NOW(a_count_vs_empty, count_nonzero, !out_now_empty)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== tb/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: a directed burst, then random
// enqueue/dequeue traffic under three idle profiles, checked against a local model.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

  localparam int CAPACITY   = 16;
  localparam int RAND_WORDS = 1550;
  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN      = 8;

  typedef struct packed {
    logic                             op;
    logic signed [spq_pkg::DataW-1:0] data;
    logic signed [spq_pkg::DataW-1:0] prio;
  } pq_word_t;

  typedef struct packed {
    logic [1:0]                       status;
    logic signed [spq_pkg::DataW-1:0] head_data;
    logic signed [spq_pkg::DataW-1:0] head_prio;
    logic                             empty;
    logic [spq_pkg::CountW-1:0]       count;
  } pq_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_op = spq_pkg::OP_ENQ;
  logic signed [spq_pkg::DataW-1:0] in_item_data = '0;
  logic signed [spq_pkg::DataW-1:0] in_item_priority = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       out_status;
  logic signed [spq_pkg::DataW-1:0] out_head_data;
  logic signed [spq_pkg::DataW-1:0] out_head_priority;
  logic                             out_now_empty;
  logic [spq_pkg::CountW-1:0]       out_entry_count;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_item_data      (in_item_data),
    .in_item_priority  (in_item_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_head_data     (out_head_data),
    .out_head_priority (out_head_priority),
    .out_now_empty     (out_now_empty),
    .out_entry_count   (out_entry_count)
  );

  always #10 clk = ~clk;

  pq_word_t   pending_words[$];
  pq_result_t expected_results[$];

  // model of the queue contents, slot 0 is the head
  logic signed [spq_pkg::DataW-1:0] slot_data[CAPACITY];
  logic signed [spq_pkg::DataW-1:0] slot_prio[CAPACITY];
  int held = 0;

  int words_sent = 0;     // updated with NBA so every block sees a stable value
  int results_seen = 0;
  int issued = 0;
  int directed_len = 0;
  int phase1_at = 0;
  int phase2_at = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic pq_result_t queue_apply(pq_word_t w);
    pq_result_t r;
    int pos;
    r = '0;
    if (w.op == spq_pkg::OP_ENQ) begin
      if (held >= CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        // stable: new word goes after every entry of equal priority
        while (pos < held && slot_prio[pos] <= w.prio) pos++;
        for (int i = held; i > pos; i--) begin
          slot_data[i] = slot_data[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_data[pos] = w.data;
        slot_prio[pos] = w.prio;
        held++;
      end
    end else if (held == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.head_data = slot_data[0];
      r.head_prio = slot_prio[0];
      for (int i = 1; i < held; i++) begin
        slot_data[i-1] = slot_data[i];
        slot_prio[i-1] = slot_prio[i];
      end
      held--;
    end
    r.status = (r.status == spq_pkg::ST_DONE) ? spq_pkg::ST_DONE : r.status;
    r.empty = (held == 0);
    r.count = held[spq_pkg::CountW-1:0];
    return r;
  endfunction

  // idle percentages: 0 sender, 1 receiver
  function automatic int idle_pct(bit receiver);
    if (words_sent < phase1_at) return receiver ? 50 : 19;
    if (words_sent < phase2_at) return receiver ? 19 : 50;
    return 0;
  endfunction

  function automatic logic signed [spq_pkg::DataW-1:0] rand_prio();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $signed($urandom_range(0, 15)) - 8;   // many ties
    if (pick < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh7fffffff - $urandom_range(0, 3);
      default: return 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic add_word(logic op, logic signed [spq_pkg::DataW-1:0] d,
                          logic signed [spq_pkg::DataW-1:0] p);
    pq_word_t w;
    w.op = op;
    w.data = d;
    w.prio = p;
    pending_words.push_back(w);
  endtask

  task automatic note_mismatch(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    logic fire;
    logic load;
    pq_word_t w;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) words_sent <= words_sent + 1;
      if (!in_valid || fire) begin
        load = pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0);
        // at phase boundaries hold off until the queue has answered everything
        if (load && (issued == directed_len || issued == phase1_at || issued == phase2_at))
          load = !in_valid && words_sent == results_seen;
        if (load) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_op <= w.op;
          in_item_data <= w.data;
          in_item_priority <= w.prio;
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    pq_word_t   w;
    pq_result_t want;
    pq_result_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        w.op = in_op;
        w.data = in_item_data;
        w.prio = in_item_priority;
        expected_results.push_back(queue_apply(w));
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got.status = out_status;
        got.head_data = out_head_data;
        got.head_prio = out_head_priority;
        got.empty = out_now_empty;
        got.count = out_entry_count;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result word with nothing pending: status %0d count %0d",
                                  got.status, got.count));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.head_data !== want.head_data ||
              got.head_prio !== want.head_prio || got.empty !== want.empty ||
              got.count !== want.count)
            note_mismatch($sformatf(
              "result %0d: status %0d/%0d data %0d/%0d prio %0d/%0d empty %0d/%0d count %0d/%0d",
              results_seen, want.status, got.status, want.head_data, got.head_data,
              want.head_prio, got.head_prio, want.empty, got.empty, want.count, got.count));
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("sorted_priority_queue test failed");
      $finish;
    end
  end

  initial begin
    int seg_left;
    int enq_pct;
    int total;
    seg_left = 0;
    enq_pct = 50;

    // directed: empty dequeue, extremes, ties, fill, refused enqueue, partial drain
    add_word(spq_pkg::OP_DEQ, 32'sh12345678, 32'sh0);
    add_word(spq_pkg::OP_ENQ, 32'sh7fffffff, 32'sh7fffffff);
    add_word(spq_pkg::OP_ENQ, 32'sh80000000, 32'sh80000000);
    add_word(spq_pkg::OP_ENQ, 32'sh0, 32'sh0);
    add_word(spq_pkg::OP_ENQ, -32'sd1, -32'sd1);
    add_word(spq_pkg::OP_ENQ, 32'sd1, 32'sh0);
    add_word(spq_pkg::OP_ENQ, 32'sd2, 32'sh0);
    add_word(spq_pkg::OP_ENQ, 32'sd3, 32'sh7fffffff);
    add_word(spq_pkg::OP_ENQ, 32'sd4, 32'sh80000000);
    add_word(spq_pkg::OP_ENQ, 32'sd10, 32'sd5);
    add_word(spq_pkg::OP_ENQ, 32'sd11, -32'sd5);
    add_word(spq_pkg::OP_ENQ, 32'sd12, 32'sh0);
    add_word(spq_pkg::OP_ENQ, 32'sd13, 32'sd3);
    add_word(spq_pkg::OP_ENQ, 32'sd14, 32'sd3);
    add_word(spq_pkg::OP_ENQ, 32'sd15, -32'sd100);
    add_word(spq_pkg::OP_ENQ, 32'sd16, 32'sd1000);
    add_word(spq_pkg::OP_ENQ, 32'sh55555555, 32'sh0);
    add_word(spq_pkg::OP_ENQ, 32'shaaaaaaaa, 32'sh0);      // queue full: refused
    repeat (6) add_word(spq_pkg::OP_DEQ, $urandom, $urandom);
    directed_len = pending_words.size();

    // random: segments that lean toward filling, draining or balance
    repeat (RAND_WORDS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 20;
          default: enq_pct = 55;
        endcase
      end
      seg_left--;
      add_word(($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
               $urandom, rand_prio());
    end
    total = pending_words.size();
    phase1_at = directed_len + (total - directed_len) / 3;
    phase2_at = directed_len + 2 * (total - directed_len) / 3;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || words_sent != results_seen)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatches == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/sorted_priority_queue_tb.sv
